FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the banded Jacobi solver.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BJS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BJS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bjs_pkg.sv
// Shared types and codes of the banded Jacobi solver.
// No dependencies; the top, controller and datapath refer to it by scoped names.
package bjs_pkg;

	// Input item operations
	localparam logic [1:0] OP_MAT   = 2'd0;
	localparam logic [1:0] OP_RHS   = 2'd1;
	localparam logic [1:0] OP_X0    = 2'd2;
	localparam logic [1:0] OP_START = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_CONV  = 2'd0;
	localparam logic [1:0] ST_FIXED = 2'd1;
	localparam logic [1:0] ST_CAP   = 2'd2;
	localparam logic [1:0] ST_ZDIAG = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] REG_SIZE  = 3'd0;
	localparam logic [2:0] REG_BAND  = 3'd1;
	localparam logic [2:0] REG_TOL   = 3'd2;
	localparam logic [2:0] REG_MODE  = 3'd3;
	localparam logic [2:0] REG_FIXED = 3'd4;
	localparam logic [2:0] REG_CAP   = 3'd5;

	localparam int CFG_DW = 31;

	typedef struct packed {
		logic [1:0]         operation;
		logic [4:0]         row;
		logic [4:0]         col;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [4:0]         out_row;
		logic signed [31:0] solution;
		logic [16:0]        sweeps_done;
		logic [1:0]         status;
		logic               last;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic diag_rd;
		logic rhs_rd;
		logic acc_clr;
		logic band_rd;
		logic band_diag;
		logic skip_diag;
		logic div_start;
		logic nxt_wr;
		logic copy_rd;
		logic res_clr;
		logic res_r;
		logic res_sq;
		logic res_acc;
		logic out_rd;
		logic out_ld;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic diag_zero;
		logic div_done;
		logic res_small;
	} stat_t;

endpackage

FILE: rtl/banded_jacobi_solver_top.sv
// Top level of the banded Jacobi solver: configuration registers and the
// controller/datapath pair. Depends on bjs_pkg, bjs_ctrl, bjs_datapath, assert_macros.svh.
//
//   channel | signals                         | moves
//   --------+---------------------------------+------------------------------------
//   req     | req_valid, req_ready, req       | load item or start item
//   rsp     | rsp_valid, rsp_ready, rsp       | one solution element per row
//   cfg     | cfg_we, cfg_index, cfg_data     | register write, no wait
//
// Load items are taken while idle and written straight into the stores. A
// start item runs a diagonal check over the rows; per sweep and row, a band
// multiply-accumulate and a division in the bit-serial divider; a copy-back
// pass per sweep; and a residual pass over the rows after each sweep unless
// the fixed-sweep mode is set. Each result is read, registered and offered in
// turn; a stalled result holds and the block takes no item until the last one
// is taken. Reset is asynchronous; the stores come up undefined and need loading.
`include "assert_macros.svh"

module banded_jacobi_solver_top #(
	parameter int MAX_SIZE      = 32,
	parameter int MAX_HALF_BAND = 31
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  bjs_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output bjs_pkg::rsp_t               rsp,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [bjs_pkg::CFG_DW-1:0]  cfg_data
);

	localparam int IW = $clog2(MAX_SIZE);

	logic [5:0]  size_q;
	logic [4:0]  band_q;
	logic [30:0] tol_q;
	logic        mode_q;
	logic [15:0] fixed_q;
	logic [15:0] cap_q;

	bjs_pkg::cmd_t      cmd;
	bjs_pkg::stat_t     st;
	logic [IW-1:0]      row_idx, col_idx;
	logic [16:0]        sweeps;
	logic [1:0]         status;
	logic               last;
	logic signed [31:0] solution;

	// Configuration registers; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= 6'd32;
			band_q  <= 5'd1;
			tol_q   <= 31'd66;
			mode_q  <= 1'b0;
			fixed_q <= 16'd10;
			cap_q   <= 16'd1000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bjs_pkg::REG_SIZE:  size_q  <= cfg_data[5:0];
				bjs_pkg::REG_BAND:  band_q  <= cfg_data[4:0];
				bjs_pkg::REG_TOL:   tol_q   <= cfg_data[30:0];
				bjs_pkg::REG_MODE:  mode_q  <= cfg_data[0];
				bjs_pkg::REG_FIXED: fixed_q <= cfg_data[15:0];
				bjs_pkg::REG_CAP:   cap_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Sequencer: owns row/column counters, sweep count and status
	bjs_ctrl #(.MAX_SIZE(MAX_SIZE), .MAX_HALF_BAND(MAX_HALF_BAND)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_op(req.operation), .req_ready(req_ready),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.sys_size(size_q), .half_band(band_q), .stop_mode(mode_q),
		.fixed_sweeps(fixed_q), .sweep_cap(cap_q),
		.st(st), .cmd(cmd), .row_idx(row_idx), .col_idx(col_idx),
		.sweeps(sweeps), .status(status), .last(last)
	);

	// Stores and arithmetic
	bjs_datapath #(.MAX_SIZE(MAX_SIZE)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req(req),
		.row_idx(row_idx), .col_idx(col_idx), .tolerance(tol_q),
		.st(st), .solution(solution)
	);

	// Result fields hold while the controller waits on rsp_ready
	assign rsp.out_row     = 5'(row_idx);
	assign rsp.solution    = solution;
	assign rsp.sweeps_done = sweeps;
	assign rsp.status      = status;
	assign rsp.last        = last;

	`BJS_ASSERT_IMP(a_no_overlap, rsp_valid, !req_ready, "item taken while results pending")
	`BJS_ASSERT_NXT(a_idle_after_last, rsp_valid && rsp_ready && rsp.last, req_ready, "not idle after final result")
	`BJS_ASSERT_NXT(a_start_busy, req_valid && req_ready && req.operation == bjs_pkg::OP_START, !req_ready, "start item did not start a run")
	`BJS_ASSERT_IMP(a_zdiag_count, rsp_valid && rsp.status == bjs_pkg::ST_ZDIAG, rsp.sweeps_done == 17'd0, "sweeps counted on zero diagonal")

endmodule

FILE: rtl/bjs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bjs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/bjs_div.sv
// Radix-2 restoring divider: (num << 16) / den, truncated toward zero,
// saturated to signed 32 bits. One quotient bit per cycle. Depends on nothing.
module bjs_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [47:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quo
);

	localparam int QW = 63;
	localparam logic [5:0] STEPS = 6'(QW);

	logic          busy_q;
	logic          done_q;
	logic [5:0]    cnt_q;
	logic [31:0]   rem_q;
	logic [QW-1:0] q_q;
	logic [31:0]   den_q;
	logic          neg_q;
	logic [32:0]   sh;
	logic [32:0]   diff;
	logic [46:0]   num_mag;

	assign num_mag = num[47] ? 47'(-num) : 47'(num);
	assign sh      = {rem_q, q_q[QW-1]};
	assign diff    = sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= {num_mag, 16'h0000};
			den_q <= den[31] ? 32'(-den) : 32'(den);
			neg_q <= num[47] ^ den[31];
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				q_q   <= {q_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= sh[31:0];
				q_q   <= {q_q[QW-2:0], 1'b0};
			end
		end
	end

	// Saturate magnitude to the signed 32-bit range
	always_comb begin
		if (!neg_q) begin
			quo = (q_q > QW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : signed'(q_q[31:0]);
		end else begin
			quo = (q_q > QW'(32'h8000_0000)) ? 32'sh8000_0000 : signed'(-q_q[31:0]);
		end
	end

	assign done = done_q;

endmodule

FILE: rtl/bjs_ctrl.sv
// Sequencer of the banded Jacobi solver: diagonal check, sweeps, residual
// passes and result delivery. Depends on bjs_pkg.
module bjs_ctrl #(
	parameter int MAX_SIZE      = 32,
	parameter int MAX_HALF_BAND = 31
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic [1:0]                  req_op,
	output logic                        req_ready,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	input  logic [5:0]                  sys_size,
	input  logic [4:0]                  half_band,
	input  logic                        stop_mode,
	input  logic [15:0]                 fixed_sweeps,
	input  logic [15:0]                 sweep_cap,
	input  bjs_pkg::stat_t              st,
	output bjs_pkg::cmd_t               cmd,
	output logic [$clog2(MAX_SIZE)-1:0] row_idx,
	output logic [$clog2(MAX_SIZE)-1:0] col_idx,
	output logic [16:0]                 sweeps,
	output logic [1:0]                  status,
	output logic                        last
);

	localparam int IW = $clog2(MAX_SIZE);
	localparam int NW = $clog2(MAX_SIZE + 1);

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_DG_RD    = 5'd1;
	localparam logic [4:0] S_DG_CK    = 5'd2;
	localparam logic [4:0] S_ROW      = 5'd3;
	localparam logic [4:0] S_BAND     = 5'd4;
	localparam logic [4:0] S_DRAIN    = 5'd5;
	localparam logic [4:0] S_DIV_GO   = 5'd6;
	localparam logic [4:0] S_DIV_WAIT = 5'd7;
	localparam logic [4:0] S_COPY     = 5'd8;
	localparam logic [4:0] S_COPY_END = 5'd9;
	localparam logic [4:0] S_RES_R    = 5'd10;
	localparam logic [4:0] S_RES_SQ   = 5'd11;
	localparam logic [4:0] S_RES_ACC  = 5'd12;
	localparam logic [4:0] S_RES_DEC  = 5'd13;
	localparam logic [4:0] S_OUT_RD   = 5'd14;
	localparam logic [4:0] S_OUT_LD   = 5'd15;
	localparam logic [4:0] S_OUT_V    = 5'd16;

	logic [4:0]    state_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic          drain_q;
	logic          sweep_ph_q;
	logic [16:0]   count_q;
	logic [1:0]    status_q;

	logic [NW-1:0] n_eff;
	logic [IW-1:0] n_m1;
	logic [4:0]    l_eff;
	logic [9:0]    i10, l10, n10, lo10, hi10;
	logic [IW-1:0] lo, hi;
	logic [16:0]   cnt_inc;
	logic [15:0]   cap_eff;

	always_comb begin
		if (sys_size == 6'd0) begin
			n_eff = NW'(1);
		end else if (32'(sys_size) > MAX_SIZE) begin
			n_eff = NW'(MAX_SIZE);
		end else begin
			n_eff = NW'(sys_size);
		end
	end

	assign n_m1  = IW'(n_eff - NW'(1));
	assign l_eff = (32'(half_band) > MAX_HALF_BAND) ? 5'(MAX_HALF_BAND) : half_band;
	assign i10   = 10'(i_q);
	assign l10   = 10'(l_eff);
	assign n10   = 10'(n_eff);
	assign lo10  = (i10 >= l10) ? i10 - l10 : 10'd0;
	assign hi10  = (i10 + l10 < n10) ? i10 + l10 : n10 - 10'd1;
	assign lo    = IW'(lo10);
	assign hi    = IW'(hi10);
	assign cnt_inc = count_q + 17'd1;
	assign cap_eff = (sweep_cap == 16'd0) ? 16'd1 : sweep_cap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			i_q        <= '0;
			j_q        <= '0;
			drain_q    <= 1'b0;
			sweep_ph_q <= 1'b0;
			count_q    <= '0;
			status_q   <= bjs_pkg::ST_CONV;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid && req_op == bjs_pkg::OP_START) begin
						i_q     <= '0;
						count_q <= '0;
						state_q <= S_DG_RD;
					end
				end
				S_DG_RD: state_q <= S_DG_CK;
				S_DG_CK: begin
					if (st.diag_zero) begin
						status_q <= bjs_pkg::ST_ZDIAG;
						i_q      <= '0;
						state_q  <= S_OUT_RD;
					end else if (i_q == n_m1) begin
						i_q        <= '0;
						sweep_ph_q <= 1'b1;
						state_q    <= S_ROW;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_DG_RD;
					end
				end
				S_ROW: begin
					j_q     <= lo;
					drain_q <= 1'b0;
					state_q <= S_BAND;
				end
				S_BAND: begin
					if (j_q == hi) begin
						state_q <= S_DRAIN;
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				S_DRAIN: begin
					drain_q <= ~drain_q;
					if (drain_q) begin
						state_q <= sweep_ph_q ? S_DIV_GO : S_RES_R;
					end
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (st.div_done) begin
						if (i_q == n_m1) begin
							j_q     <= '0;
							state_q <= S_COPY;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= S_ROW;
						end
					end
				end
				S_COPY: begin
					if (j_q == n_m1) begin
						state_q <= S_COPY_END;
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				S_COPY_END: begin
					count_q <= cnt_inc;
					i_q     <= '0;
					if (stop_mode) begin
						if (cnt_inc == 17'(fixed_sweeps) + 17'd1) begin
							status_q <= bjs_pkg::ST_FIXED;
							state_q  <= S_OUT_RD;
						end else begin
							state_q <= S_ROW;
						end
					end else begin
						sweep_ph_q <= 1'b0;
						state_q    <= S_ROW;
					end
				end
				S_RES_R:  state_q <= S_RES_SQ;
				S_RES_SQ: state_q <= S_RES_ACC;
				S_RES_ACC: begin
					if (i_q == n_m1) begin
						state_q <= S_RES_DEC;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_ROW;
					end
				end
				S_RES_DEC: begin
					i_q <= '0;
					if (st.res_small) begin
						status_q <= bjs_pkg::ST_CONV;
						state_q  <= S_OUT_RD;
					end else if (count_q >= 17'(cap_eff)) begin
						status_q <= bjs_pkg::ST_CAP;
						state_q  <= S_OUT_RD;
					end else begin
						sweep_ph_q <= 1'b1;
						state_q    <= S_ROW;
					end
				end
				S_OUT_RD: state_q <= S_OUT_LD;
				S_OUT_LD: state_q <= S_OUT_V;
				S_OUT_V: begin
					if (rsp_ready) begin
						if (i_q == n_m1) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= S_OUT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:     cmd.load = req_valid && req_op != bjs_pkg::OP_START;
			S_DG_RD:    cmd.diag_rd = 1'b1;
			S_ROW: begin
				cmd.rhs_rd  = 1'b1;
				cmd.acc_clr = 1'b1;
				cmd.res_clr = !sweep_ph_q && i_q == '0;
			end
			S_BAND: begin
				cmd.band_rd   = 1'b1;
				cmd.band_diag = j_q == i_q;
				cmd.skip_diag = sweep_ph_q;
			end
			S_DIV_GO:   cmd.div_start = 1'b1;
			S_DIV_WAIT: cmd.nxt_wr = st.div_done;
			S_COPY:     cmd.copy_rd = 1'b1;
			S_RES_R:    cmd.res_r = 1'b1;
			S_RES_SQ:   cmd.res_sq = 1'b1;
			S_RES_ACC:  cmd.res_acc = 1'b1;
			S_OUT_RD:   cmd.out_rd = 1'b1;
			S_OUT_LD:   cmd.out_ld = 1'b1;
			default:    cmd = '0;
		endcase
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = state_q == S_OUT_V;
	assign row_idx   = i_q;
	assign col_idx   = (state_q == S_BAND || state_q == S_COPY) ? j_q : i_q;
	assign sweeps    = count_q;
	assign status    = status_q;
	assign last      = i_q == n_m1;

endmodule

FILE: rtl/bjs_datapath.sv
// Datapath of the banded Jacobi solver: stores, band multiply-accumulate,
// divider, residual norm and result register. Depends on bjs_pkg, bjs_ram, bjs_div.
module bjs_datapath #(
	parameter int MAX_SIZE = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bjs_pkg::cmd_t               cmd,
	input  bjs_pkg::req_t               req,
	input  logic [$clog2(MAX_SIZE)-1:0] row_idx,
	input  logic [$clog2(MAX_SIZE)-1:0] col_idx,
	input  logic [30:0]                 tolerance,
	output bjs_pkg::stat_t              st,
	output logic signed [31:0]          solution
);

	localparam int IW    = $clog2(MAX_SIZE);
	localparam int AW    = $clog2(MAX_SIZE * MAX_SIZE);
	localparam int ACC_W = 48 + $clog2(2 * MAX_SIZE) + 1;
	localparam logic signed [ACC_W:0] NUM_HI = (ACC_W + 1)'(64'sd1 <<< 46);
	localparam logic signed [ACC_W:0] RES_HI = (ACC_W + 1)'(64'sd1 <<< 31);

	logic row_ok, col_ok;
	logic mat_we, rhs_we, cur_we;
	logic [AW-1:0] mat_waddr, mat_raddr;
	logic [IW-1:0] cur_waddr;
	logic [31:0] cur_wdata;
	logic [31:0] mat_rd, rhs_rd, cur_rd, nxt_rd;

	logic                    copy_v_s1;
	logic [IW-1:0]           copy_addr_s1;
	logic                    band_v_s1, diag_s1, skip_s1;
	logic                    v_s2;
	logic signed [63:0]      prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [31:0]      d_q;
	logic signed [ACC_W:0]   num_raw, res_raw;
	logic signed [47:0]      num_c;
	logic [31:0]             rmag_q;
	logic [63:0]             sq_q, ssq_q, lim_q;
	logic [64:0]             ssq_sum;
	logic                    div_done;
	logic signed [31:0]      quo;
	logic signed [31:0]      sol_q;

	assign row_ok    = 32'(req.row) < MAX_SIZE;
	assign col_ok    = 32'(req.col) < MAX_SIZE;
	assign mat_we    = cmd.load && req.operation == bjs_pkg::OP_MAT && row_ok && col_ok;
	assign rhs_we    = cmd.load && req.operation == bjs_pkg::OP_RHS && row_ok;
	assign mat_waddr = AW'(32'(req.row) * MAX_SIZE + 32'(req.col));
	assign mat_raddr = AW'(32'(row_idx) * MAX_SIZE + 32'(col_idx));

	// Current vector: written by start-value loads and by the copy-back pass
	assign cur_we    = copy_v_s1 || (cmd.load && req.operation == bjs_pkg::OP_X0 && row_ok);
	assign cur_waddr = copy_v_s1 ? copy_addr_s1 : IW'(req.row);
	assign cur_wdata = copy_v_s1 ? nxt_rd : req.value;

	bjs_ram #(.WIDTH(32), .DEPTH(MAX_SIZE * MAX_SIZE)) u_mat (
		.clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(req.value),
		.re(cmd.diag_rd || cmd.band_rd), .raddr(mat_raddr), .rdata(mat_rd)
	);

	bjs_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_rhs (
		.clk(clk), .we(rhs_we), .waddr(IW'(req.row)), .wdata(req.value),
		.re(cmd.rhs_rd), .raddr(row_idx), .rdata(rhs_rd)
	);

	bjs_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_cur (
		.clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
		.re(cmd.band_rd || cmd.out_rd), .raddr(col_idx), .rdata(cur_rd)
	);

	bjs_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_nxt (
		.clk(clk), .we(cmd.nxt_wr), .waddr(row_idx), .wdata(quo),
		.re(cmd.copy_rd), .raddr(col_idx), .rdata(nxt_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_v_s1 <= 1'b0;
			band_v_s1 <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			copy_v_s1 <= cmd.copy_rd;
			band_v_s1 <= cmd.band_rd;
			v_s2      <= band_v_s1 && !skip_s1;
		end
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= col_idx;
		diag_s1      <= cmd.band_diag;
		skip_s1      <= cmd.band_diag && cmd.skip_diag;
		prod_s2      <= signed'(mat_rd) * signed'(cur_rd);
		if (band_v_s1 && diag_s1) begin
			d_q <= signed'(mat_rd);
		end
		// Floor each product to Q16.16 and accumulate exactly
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2 >>> 16);
		end
	end

	assign num_raw = (ACC_W + 1)'(signed'(rhs_rd)) - (ACC_W + 1)'(acc_q);
	assign res_raw = (ACC_W + 1)'(acc_q) - (ACC_W + 1)'(signed'(rhs_rd));

	always_comb begin
		if (num_raw > NUM_HI) begin
			num_c = 48'(NUM_HI);
		end else if (num_raw < -NUM_HI) begin
			num_c = 48'(-NUM_HI);
		end else begin
			num_c = 48'(num_raw);
		end
	end

	bjs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(num_c), .den(d_q), .done(div_done), .quo(quo)
	);

	// Residual: clamp, square, saturating sum
	assign ssq_sum = {1'b0, ssq_q} + {1'b0, sq_q};

	always_ff @(posedge clk) begin
		if (cmd.res_clr) begin
			ssq_q <= '0;
			lim_q <= 64'(tolerance) * 64'(tolerance);
		end else if (cmd.res_acc) begin
			ssq_q <= ssq_sum[64] ? '1 : ssq_sum[63:0];
		end
		if (cmd.res_r) begin
			if (res_raw >= RES_HI || res_raw <= -RES_HI) begin
				rmag_q <= 32'h8000_0000;
			end else begin
				rmag_q <= res_raw[ACC_W] ? 32'(-res_raw) : 32'(res_raw);
			end
		end
		if (cmd.res_sq) begin
			sq_q <= 64'(rmag_q) * 64'(rmag_q);
		end
		if (cmd.out_ld) begin
			sol_q <= signed'(cur_rd);
		end
	end

	assign st.diag_zero = mat_rd == 32'd0;
	assign st.div_done  = div_done;
	assign st.res_small = ssq_q < lim_q;
	assign solution     = sol_q;

endmodule
